// ===== rtl/core/swse_pkg.sv =====
`timescale 1ns / 1ps

package swse_pkg;

  localparam int unsigned DEPTH   = 64;
  localparam int unsigned LEVEL_W = $clog2(DEPTH + 1);
  localparam int unsigned ADDR_W  = $clog2(DEPTH);
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned OP_W    = 3;
  localparam int unsigned POS_W   = 7;
  localparam int unsigned CNT_W   = 7;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH     = 3'd0,
    OP_POP      = 3'd1,
    OP_CLEAR    = 3'd2,
    OP_REPORT   = 3'd3,
    OP_FIND_POS = 3'd4,
    OP_FIND_VAL = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_FINISH
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic pos_read;
    logic scan_start;
    logic scan_run;
    logic finish;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            empty;
    logic            scan_done;
    logic            out_free;
  } stat_t;

endpackage

// ===== rtl/core/stack_with_search_and_extremes_core.sv =====
`timescale 1ns / 1ps

// bounded lifo stack of 64 signed 32-bit words with search and extreme queries
// input channel: operation, value, position with in_valid / in_stall; an item
//   is taken at a clock edge with in_valid high and in_stall low
// output channel: status, fill_level and the query fields with out_valid /
//   out_stall; exactly one result item per input item, in order
// sequence: push, pop, clear, unused codes, find by position and any query on
//   an empty stack go from acceptance through decode to the finish step;
//   report and find by value on a non-empty stack walk the stored entries
//   one per cycle through the single read port before the finish step
// one item at a time: a new item is taken only once the last one has left
//   its finish step and the controller is back in idle
// a finished result sits in the output register while the next item is
//   taken; a stalled receiver holds the result and the following item waits
//   in its last step until the register frees up
// reset (rst, synchronous) empties the stack and drops out_valid; the entry
//   memory is not cleared, entries above the fill level are never returned
module stack_with_search_and_extremes_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [swse_pkg::OP_W-1:0]           operation,
  input  logic signed [swse_pkg::WORD_W-1:0]  value,
  input  logic [swse_pkg::POS_W-1:0]          position,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [1:0]                          status,
  output logic [swse_pkg::LEVEL_W-1:0]        fill_level,
  output logic signed [swse_pkg::WORD_W-1:0]  entry_value,
  output logic signed [swse_pkg::WORD_W-1:0]  max_value,
  output logic signed [swse_pkg::WORD_W-1:0]  min_value,
  output logic                                found,
  output logic [swse_pkg::POS_W-1:0]          match_position,
  output logic [swse_pkg::CNT_W-1:0]          match_count
);

  swse_pkg::cmd_t  cmd;
  swse_pkg::stat_t stat;

  swse_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  swse_dpath u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .operation      (operation),
    .value          (value),
    .position       (position),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .fill_level     (fill_level),
    .entry_value    (entry_value),
    .max_value      (max_value),
    .min_value      (min_value),
    .found          (found),
    .match_position (match_position),
    .match_count    (match_count)
  );

endmodule

// ===== rtl/core/swse_ctrl.sv =====
`timescale 1ns / 1ps

module swse_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  swse_pkg::stat_t stat,
  output swse_pkg::cmd_t  cmd
);

  swse_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= swse_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    unique case (state)
      swse_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = swse_pkg::S_DECODE;
        end
      end
      swse_pkg::S_DECODE: begin
        if (stat.op == swse_pkg::OP_FIND_POS) begin
          cmd.pos_read = 1'b1;
        end
        if ((stat.op == swse_pkg::OP_REPORT || stat.op == swse_pkg::OP_FIND_VAL)
            && !stat.empty) begin
          cmd.scan_start = 1'b1;
          state_next     = swse_pkg::S_SCAN;
        end else begin
          state_next = swse_pkg::S_FINISH;
        end
      end
      swse_pkg::S_SCAN: begin
        cmd.scan_run = 1'b1;
        if (stat.scan_done) begin
          state_next = swse_pkg::S_FINISH;
        end
      end
      swse_pkg::S_FINISH: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_next = swse_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = swse_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/swse_dpath.sv =====
`timescale 1ns / 1ps

module swse_dpath (
  input  logic                                clk,
  input  logic                                rst,
  input  swse_pkg::cmd_t                      cmd,
  output swse_pkg::stat_t                     stat,
  input  logic [swse_pkg::OP_W-1:0]           operation,
  input  logic signed [swse_pkg::WORD_W-1:0]  value,
  input  logic [swse_pkg::POS_W-1:0]          position,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [1:0]                          status,
  output logic [swse_pkg::LEVEL_W-1:0]        fill_level,
  output logic signed [swse_pkg::WORD_W-1:0]  entry_value,
  output logic signed [swse_pkg::WORD_W-1:0]  max_value,
  output logic signed [swse_pkg::WORD_W-1:0]  min_value,
  output logic                                found,
  output logic [swse_pkg::POS_W-1:0]          match_position,
  output logic [swse_pkg::CNT_W-1:0]          match_count
);

  logic signed [swse_pkg::WORD_W-1:0] mem [swse_pkg::DEPTH];

  logic [swse_pkg::OP_W-1:0]          op_q;
  logic signed [swse_pkg::WORD_W-1:0] val_q;
  logic [swse_pkg::POS_W-1:0]         pos_q;
  logic [swse_pkg::LEVEL_W-1:0]       level;

  logic                               rd_en;
  logic [swse_pkg::ADDR_W-1:0]        rd_addr;
  logic signed [swse_pkg::WORD_W-1:0] rd_data;

  logic [swse_pkg::LEVEL_W-1:0]       cnt;
  logic                               rd_pend;
  logic [swse_pkg::POS_W-1:0]         rd_pos;
  logic                               issue;

  logic                               have_ext;
  logic signed [swse_pkg::WORD_W-1:0] mx;
  logic signed [swse_pkg::WORD_W-1:0] mn;
  logic [swse_pkg::POS_W-1:0]         mpos;
  logic [swse_pkg::CNT_W-1:0]         mcnt;

  logic                               empty;
  logic                               full;
  logic                               bad_pos;
  logic                               wr_en;

  logic [1:0]                         res_status;
  logic [swse_pkg::LEVEL_W-1:0]       level_next;
  logic signed [swse_pkg::WORD_W-1:0] res_entry;
  logic signed [swse_pkg::WORD_W-1:0] res_max;
  logic signed [swse_pkg::WORD_W-1:0] res_min;
  logic                               res_found;
  logic [swse_pkg::POS_W-1:0]         res_mpos;
  logic [swse_pkg::CNT_W-1:0]         res_mcnt;

  assign empty   = (level == '0);
  assign full    = (level == swse_pkg::LEVEL_W'(swse_pkg::DEPTH));
  assign bad_pos = (pos_q == '0) || (swse_pkg::LEVEL_W'(pos_q) > level);
  assign issue   = cmd.scan_run && (cnt != level);
  assign rd_en   = cmd.pos_read || issue;

  // scan walks from the top of the stack downwards
  always_comb begin
    if (cmd.pos_read) begin
      rd_addr = swse_pkg::ADDR_W'(level - swse_pkg::LEVEL_W'(pos_q));
    end else begin
      rd_addr = swse_pkg::ADDR_W'(level - cnt - swse_pkg::LEVEL_W'(1));
    end
  end

  assign stat.op        = op_q;
  assign stat.empty     = empty;
  assign stat.scan_done = (cnt == level) && !rd_pend;
  assign stat.out_free  = !out_valid || !out_stall;

  assign wr_en = cmd.finish && (op_q == swse_pkg::OP_PUSH) && !full;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[swse_pkg::ADDR_W'(level)] <= val_q;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q  <= operation;
      val_q <= value;
      pos_q <= position;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level     <= '0;
      out_valid <= 1'b0;
      rd_pend   <= 1'b0;
      cnt       <= '0;
    end else begin
      if (cmd.finish) begin
        level     <= level_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (cmd.scan_start) begin
        cnt     <= '0;
        rd_pend <= 1'b0;
      end else begin
        rd_pend <= issue;
        if (issue) begin
          cnt <= cnt + swse_pkg::LEVEL_W'(1);
        end
      end
    end
  end

  // accumulate on the registered read data
  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      have_ext <= 1'b0;
      mpos     <= '0;
      mcnt     <= '0;
    end else begin
      if (issue) begin
        rd_pos <= swse_pkg::POS_W'(cnt + swse_pkg::LEVEL_W'(1));
      end
      if (rd_pend) begin
        have_ext <= 1'b1;
        if (!have_ext || rd_data > mx) begin
          mx <= rd_data;
        end
        if (!have_ext || rd_data < mn) begin
          mn <= rd_data;
        end
        if (rd_data == val_q) begin
          if (mcnt == '0) begin
            mpos <= rd_pos;
          end
          mcnt <= mcnt + swse_pkg::CNT_W'(1);
        end
      end
    end
  end

  always_comb begin
    res_status = swse_pkg::ST_OK;
    level_next = level;
    res_entry  = '0;
    res_max    = '0;
    res_min    = '0;
    res_found  = 1'b0;
    res_mpos   = '0;
    res_mcnt   = '0;
    case (op_q)
      swse_pkg::OP_PUSH: begin
        if (full) begin
          res_status = swse_pkg::ST_FULL;
        end else begin
          level_next = level + swse_pkg::LEVEL_W'(1);
        end
      end
      swse_pkg::OP_POP: begin
        if (empty) begin
          res_status = swse_pkg::ST_EMPTY;
        end else begin
          level_next = level - swse_pkg::LEVEL_W'(1);
        end
      end
      swse_pkg::OP_CLEAR: begin
        if (empty) begin
          res_status = swse_pkg::ST_EMPTY;
        end else begin
          level_next = '0;
        end
      end
      swse_pkg::OP_REPORT: begin
        if (empty) begin
          res_status = swse_pkg::ST_EMPTY;
        end else begin
          res_max = mx;
          res_min = mn;
        end
      end
      swse_pkg::OP_FIND_POS: begin
        if (empty) begin
          res_status = swse_pkg::ST_EMPTY;
        end else if (bad_pos) begin
          res_status = swse_pkg::ST_NOT_FOUND;
        end else begin
          res_entry = rd_data;
        end
      end
      swse_pkg::OP_FIND_VAL: begin
        if (empty) begin
          res_status = swse_pkg::ST_EMPTY;
        end else if (mcnt == '0) begin
          res_status = swse_pkg::ST_NOT_FOUND;
        end else begin
          res_found = 1'b1;
          res_mpos  = mpos;
          res_mcnt  = mcnt;
        end
      end
      default: begin
        res_status = swse_pkg::ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      status         <= res_status;
      fill_level     <= level_next;
      entry_value    <= res_entry;
      max_value      <= res_max;
      min_value      <= res_min;
      found          <= res_found;
      match_position <= res_mpos;
      match_count    <= res_mcnt;
    end
  end

endmodule
